>>> rtl/core/tpe_pkg.sv
// ----------------------------------------------------------------------------
// tpe_pkg
// Shared types, constants and tables for the turtle pose engine.
// ----------------------------------------------------------------------------
package tpe_pkg;

	localparam int STACK_DEPTH  = 32;
	localparam int CORDIC_STEPS = 24;
	localparam int STACK_AW     = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CNT_W        = $clog2(STACK_DEPTH + 1);
	localparam int LIM_W        = (CNT_W > 6) ? CNT_W : 6;
	localparam int STEP_W       = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

	// Angle conversion: one turn is 2 * 180 * 128 units of 1/128 degree.
	localparam int HALF_CIRCLE_DEG = 180;
	localparam int UNITS_PER_TURN  = 2 * HALF_CIRCLE_DEG * 128;
	localparam int TURN_DIV        = UNITS_PER_TURN / 1024;
	localparam longint BAM_Q       = (64'd1 << 22) / TURN_DIV;
	localparam longint BAM_R       = (64'd1 << 22) % TURN_DIV;
	localparam longint BAM_HALF    = (TURN_DIV - 1) / 2;
	localparam longint BAM_RECIP   = ((64'd1 << 28) + TURN_DIV - 1) / TURN_DIV;

	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

	typedef enum logic [2:0] {
		CMD_DRAW    = 3'd0,
		CMD_MOVE    = 3'd1,
		CMD_LEFT    = 3'd2,
		CMD_RIGHT   = 3'd3,
		CMD_PUSH    = 3'd4,
		CMD_POP     = 3'd5,
		CMD_RESTART = 3'd6,
		CMD_NONE    = 3'd7
	} tpe_cmd_t;

	typedef enum logic [1:0] {
		STS_OK  = 2'd0,
		STS_OVF = 2'd1,
		STS_UNF = 2'd2,
		STS_SAT = 2'd3
	} tpe_status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_CORDIC,
		ST_PROD,
		ST_LO,
		ST_HI,
		ST_DISP,
		ST_ANG1,
		ST_ANG2,
		ST_DONE
	} tpe_state_t;

	typedef enum logic [2:0] {
		REG_X_SCALE  = 3'd0,
		REG_Y_SCALE  = 3'd1,
		REG_START_X  = 3'd2,
		REG_START_Y  = 3'd3,
		REG_START_H  = 3'd4,
		REG_STK_LIM  = 3'd5
	} tpe_reg_t;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] h;
	} tpe_pose_t;

	typedef struct packed {
		logic               done;
		logic signed [33:0] cos;
		logic signed [33:0] sin;
	} tpe_trig_t;

	// Arctangent of 2^-i in binary-angle units.
	function automatic logic [31:0] atan_lut(input logic [4:0] idx);
		logic [31:0] v;
		unique case (idx)
			5'd0:  v = 32'h20000000;
			5'd1:  v = 32'h12E4051E;
			5'd2:  v = 32'h09FB385B;
			5'd3:  v = 32'h051111D4;
			5'd4:  v = 32'h028B0D43;
			5'd5:  v = 32'h0145D7E1;
			5'd6:  v = 32'h00A2F61E;
			5'd7:  v = 32'h00517C55;
			5'd8:  v = 32'h0028BE53;
			5'd9:  v = 32'h00145F2F;
			5'd10: v = 32'h000A2F98;
			5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6;
			5'd13: v = 32'h000145F3;
			5'd14: v = 32'h0000A2FA;
			5'd15: v = 32'h0000517D;
			5'd16: v = 32'h000028BE;
			5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A30;
			5'd19: v = 32'h00000518;
			5'd20: v = 32'h0000028C;
			5'd21: v = 32'h00000146;
			5'd22: v = 32'h000000A3;
			5'd23: v = 32'h00000051;
			5'd24: v = 32'h00000029;
			5'd25: v = 32'h00000014;
			5'd26: v = 32'h0000000A;
			5'd27: v = 32'h00000005;
			5'd28: v = 32'h00000003;
			5'd29: v = 32'h00000001;
			5'd30: v = 32'h00000001;
			5'd31: v = 32'h00000000;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage

>>> rtl/core/tpe_stack_ram.sv
// ----------------------------------------------------------------------------
// tpe_stack_ram
// Pose stack storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tpe_stack_ram
	import tpe_pkg::*;
(
	input  logic                clk,
	input  logic                we,
	input  logic [STACK_AW-1:0] waddr,
	input  tpe_pose_t           wdata,
	input  logic                re,
	input  logic [STACK_AW-1:0] raddr,
	output tpe_pose_t           rdata
);

	tpe_pose_t mem [STACK_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/core/tpe_angle.sv
// ----------------------------------------------------------------------------
// tpe_angle
// Two-stage conversion from 1/128 degree units to a 32-bit binary angle.
// ----------------------------------------------------------------------------
module tpe_angle
	import tpe_pkg::*;
(
	input  logic               clk,
	input  logic signed [16:0] units,
	output logic [31:0]        bam
);

	// The quotient splits into an exact part and a small remainder part that
	// is divided by a reciprocal multiply, exact for the remainder's range.
	logic [16:0] mag;
	logic        neg_s1;
	logic [33:0] base_s1;
	logic [22:0] rem_s1;
	logic [45:0] rprod;
	logic [31:0] q;

	assign mag = units[16] ? 17'(-units) : 17'(units);

	always_ff @(posedge clk) begin
		neg_s1  <= units[16];
		base_s1 <= 34'(mag) * 34'(BAM_Q);
		rem_s1  <= 23'(23'(mag) * 23'(BAM_R) + 23'(BAM_HALF));
	end

	assign rprod = 46'(rem_s1) * 46'(BAM_RECIP);
	assign q     = 32'(base_s1 + 34'(rprod >> 28));

	always_ff @(posedge clk) begin
		bam <= neg_s1 ? (32'd0 - q) : q;
	end

endmodule

>>> rtl/core/tpe_cordic.sv
// ----------------------------------------------------------------------------
// tpe_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module tpe_cordic
	import tpe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] heading,
	output tpe_trig_t   res
);

	logic               busy_q, fin_q, done_q, neg_q;
	logic [STEP_W-1:0]  step_q;
	logic signed [33:0] x_q, y_q, xs, ys, cos_q, sin_q;
	logic signed [32:0] z_q, at;
	logic [31:0]        hfold;
	logic               fold;

	assign fold  = (heading[31:30] == 2'd1) || (heading[31:30] == 2'd2);
	assign hfold = fold ? (heading + 32'h8000_0000) : heading;
	assign xs    = x_q >>> step_q;
	assign ys    = y_q >>> step_q;
	assign at    = signed'(33'(atan_lut(5'(step_q))));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= fin_q;
			fin_q  <= busy_q && (step_q == STEP_W'(CORDIC_STEPS - 1));
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && (step_q == STEP_W'(CORDIC_STEPS - 1))) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q  <= fold;
			x_q    <= CORDIC_GAIN;
			y_q    <= '0;
			z_q    <= signed'(33'(signed'(hfold)));
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (!z_q[32]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
		if (fin_q) begin
			cos_q <= neg_q ? -x_q : x_q;
			sin_q <= neg_q ? -y_q : y_q;
		end
	end

	assign res.done = done_q;
	assign res.cos  = cos_q;
	assign res.sin  = sin_q;

	ap_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !start) else $error("cordic restarted while busy");
	ap_fin_follows: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |=> done_q && !busy_q) else $error("cordic finish sequence broken");
	ap_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("cordic done longer than one cycle");

endmodule

>>> rtl/core/turtle_pose_engine_with_stack.sv
// ----------------------------------------------------------------------------
// turtle_pose_engine_with_stack
// Turtle pose engine: pose registers, CORDIC stepping and a pose stack in RAM.
// ----------------------------------------------------------------------------
// A draw or move runs 24 CORDIC iterations and then the scaling multiplies
// before its result; a turn or restart passes through the angle-conversion
// states, and a push, a pop or the unused code goes straight to the result.
// One command is in work at a time: a new one is taken only in idle, after
// the previous result is committed. Reset puts the registers at their defaults,
// the pose at the origin with heading zero and the stack empty; the stack RAM is not cleared.
module turtle_pose_engine_with_stack
	import tpe_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	// Command stream.
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [39:0]  s_tdata,   // distance[15:0], turn_angle[32:16], zero fill
	input  logic [2:0]   s_tuser,   // command[2:0]
	// Result stream.
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [135:0] m_tdata,   // from_x, from_y, to_x, to_y, status[129:128]
	output logic         m_tuser,   // line_valid
	// Register port.
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	// ------------------------------------------------------------------
	// Configuration registers.
	// ------------------------------------------------------------------
	logic [24:0] x_scale_q, y_scale_q;
	logic [31:0] start_x_q, start_y_q;
	logic [15:0] start_h_q;
	logic [5:0]  stack_limit_q;
	logic        cfg_we;
	tpe_reg_t    cfg_idx;

	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite && pready;
	assign cfg_idx = tpe_reg_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_scale_q     <= 25'd16384;
			y_scale_q     <= 25'd16384;
			start_x_q     <= '0;
			start_y_q     <= '0;
			start_h_q     <= '0;
			stack_limit_q <= 6'd32;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_X_SCALE: x_scale_q     <= pwdata[24:0];
				REG_Y_SCALE: y_scale_q     <= pwdata[24:0];
				REG_START_X: start_x_q     <= pwdata;
				REG_START_Y: start_y_q     <= pwdata;
				REG_START_H: start_h_q     <= pwdata[15:0];
				REG_STK_LIM: stack_limit_q <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_X_SCALE: prdata = 32'(x_scale_q);
			REG_Y_SCALE: prdata = 32'(y_scale_q);
			REG_START_X: prdata = start_x_q;
			REG_START_Y: prdata = start_y_q;
			REG_START_H: prdata = 32'(start_h_q);
			REG_STK_LIM: prdata = 32'(stack_limit_q);
			default:     prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Command capture and pose state.
	// ------------------------------------------------------------------
	tpe_state_t         state_q, state_d;
	tpe_cmd_t           cmd_q;
	logic signed [15:0] dist_q;
	logic signed [16:0] ang_q;
	logic [31:0]        pose_x_q, pose_y_q, pose_h_q;
	logic [CNT_W-1:0]   cnt_q;

	logic in_xfer, out_load;
	assign s_tready = (state_q == ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_q  <= tpe_cmd_t'(s_tuser);
			dist_q <= s_tdata[15:0];
			ang_q  <= s_tdata[32:16];
		end
	end

	// ------------------------------------------------------------------
	// Angle converter, CORDIC and stack RAM.
	// ------------------------------------------------------------------
	logic signed [16:0] ang_in;
	logic [31:0]        bam;
	tpe_trig_t          trig;
	logic               cordic_start;

	// A restart converts the start heading; turns convert the command angle.
	assign ang_in = (cmd_q == CMD_RESTART) ? signed'({1'b0, start_h_q}) : ang_q;

	tpe_angle u_angle (
		.clk   (clk),
		.units (ang_in),
		.bam   (bam)
	);

	tpe_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cordic_start),
		.heading (pose_h_q),
		.res     (trig)
	);

	logic                ram_we, ram_re;
	logic [STACK_AW-1:0] ram_waddr, ram_raddr;
	tpe_pose_t           ram_wdata, ram_rdata;

	assign ram_waddr = cnt_q[STACK_AW-1:0];
	assign ram_raddr = STACK_AW'(cnt_q - 1'b1);
	assign ram_wdata = '{x: pose_x_q, y: pose_y_q, h: pose_h_q};

	tpe_stack_ram u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// ------------------------------------------------------------------
	// Step datapath: rounding to Q.20 pixels, then the scale multiply in two
	// partial products (low 18 bits unsigned, high part signed).
	// ------------------------------------------------------------------
	logic signed [49:0] prod_x, prod_y;
	logic signed [39:0] p_x_q, p_y_q;
	logic [42:0]        lo_x_q, lo_y_q;
	logic signed [47:0] hi_x_q, hi_y_q;
	logic signed [41:0] d_x_q, d_y_q;
	logic signed [66:0] tot_x, tot_y;

	assign prod_x = 50'(dist_q) * 50'(trig.cos);
	assign prod_y = 50'(dist_q) * 50'(trig.sin);
	assign tot_x  = (67'(hi_x_q) <<< 18) + 67'(signed'({1'b0, lo_x_q})) + 67'sd8388608;
	assign tot_y  = (67'(hi_y_q) <<< 18) + 67'(signed'({1'b0, lo_y_q})) + 67'sd8388608;

	always_ff @(posedge clk) begin
		if (state_q == ST_PROD) begin
			p_x_q <= 40'((prod_x + 50'sd512) >>> 10);
			p_y_q <= 40'((prod_y + 50'sd512) >>> 10);
		end
		if (state_q == ST_LO) begin
			lo_x_q <= 43'(p_x_q[17:0]) * 43'(x_scale_q);
			lo_y_q <= 43'(p_y_q[17:0]) * 43'(y_scale_q);
		end
		if (state_q == ST_HI) begin
			hi_x_q <= 48'(signed'(p_x_q[39:18])) * 48'(signed'({1'b0, x_scale_q}));
			hi_y_q <= 48'(signed'(p_y_q[39:18])) * 48'(signed'({1'b0, y_scale_q}));
		end
		if (state_q == ST_DISP) begin
			d_x_q <= 42'(tot_x >>> 24);
			d_y_q <= 42'(tot_y >>> 24);
		end
	end

	// ------------------------------------------------------------------
	// Command completion: next pose, stack update and result.
	// ------------------------------------------------------------------
	logic signed [42:0] sum_x, sum_y;
	logic [31:0]        nx, ny, nh;
	logic [CNT_W-1:0]   ncnt;
	tpe_status_t        nsts;
	logic               sat_x, sat_y, full, push_ok, pop_ok;
	logic [LIM_W-1:0]   lim_eff;

	assign sum_x = 43'(signed'(pose_x_q)) + 43'(d_x_q);
	assign sum_y = 43'(signed'(pose_y_q)) + 43'(d_y_q);
	assign sat_x = (sum_x > 43'sd2147483647) || (sum_x < -43'sd2147483648);
	assign sat_y = (sum_y > 43'sd2147483647) || (sum_y < -43'sd2147483648);

	// A limit above the RAM depth is capped at the depth.
	assign lim_eff = (LIM_W'(stack_limit_q) < LIM_W'(STACK_DEPTH))
		? LIM_W'(stack_limit_q) : LIM_W'(STACK_DEPTH);
	assign full    = (LIM_W'(cnt_q) >= lim_eff) || (LIM_W'(cnt_q) >= LIM_W'(STACK_DEPTH));
	assign push_ok = !full;
	assign pop_ok  = (cnt_q != '0) && (LIM_W'(cnt_q) <= LIM_W'(STACK_DEPTH));

	always_comb begin
		nx   = pose_x_q;
		ny   = pose_y_q;
		nh   = pose_h_q;
		ncnt = cnt_q;
		nsts = STS_OK;
		unique case (cmd_q)
			CMD_DRAW, CMD_MOVE: begin
				nx = sat_x ? (sum_x[42] ? 32'h8000_0000 : 32'h7FFF_FFFF) : sum_x[31:0];
				ny = sat_y ? (sum_y[42] ? 32'h8000_0000 : 32'h7FFF_FFFF) : sum_y[31:0];
				if (sat_x || sat_y) begin
					nsts = STS_SAT;
				end
			end
			CMD_LEFT:  nh = pose_h_q + bam;
			CMD_RIGHT: nh = pose_h_q - bam;
			CMD_PUSH: begin
				if (push_ok) begin
					ncnt = cnt_q + 1'b1;
				end else begin
					nsts = STS_OVF;
				end
			end
			CMD_POP: begin
				if (pop_ok) begin
					ncnt = cnt_q - 1'b1;
					nx   = ram_rdata.x;
					ny   = ram_rdata.y;
					nh   = ram_rdata.h;
				end else begin
					nsts = STS_UNF;
				end
			end
			CMD_RESTART: begin
				nx   = start_x_q;
				ny   = start_y_q;
				nh   = bam;
				ncnt = '0;
			end
			CMD_NONE: ;
		endcase
	end

	// The result register frees the engine from the output side: a result
	// is committed once the register is empty or being drained.
	assign out_load = (state_q == ST_DONE) && (!m_tvalid || m_tready);
	assign ram_we   = out_load && (cmd_q == CMD_PUSH) && push_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pose_x_q <= '0;
			pose_y_q <= '0;
			pose_h_q <= '0;
			cnt_q    <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (out_load) begin
				pose_x_q <= nx;
				pose_y_q <= ny;
				pose_h_q <= nh;
				cnt_q    <= ncnt;
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata <= {6'd0, nsts, ny, nx, pose_y_q, pose_x_q};
			m_tuser <= (cmd_q == CMD_DRAW);
		end
	end

	// ------------------------------------------------------------------
	// Sequencer.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cordic_start = 1'b0;
		ram_re       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				priority case (cmd_q)
					CMD_DRAW, CMD_MOVE: begin
						cordic_start = 1'b1;
						state_d      = ST_CORDIC;
					end
					CMD_LEFT, CMD_RIGHT, CMD_RESTART: state_d = ST_ANG1;
					CMD_POP: begin
						ram_re  = pop_ok;
						state_d = ST_DONE;
					end
					default: state_d = ST_DONE;
				endcase
			end
			ST_CORDIC: begin
				if (trig.done) begin
					state_d = ST_PROD;
				end
			end
			ST_PROD: state_d = ST_LO;
			ST_LO:   state_d = ST_HI;
			ST_HI:   state_d = ST_DISP;
			ST_DISP: state_d = ST_DONE;
			ST_ANG1: state_d = ST_ANG2;
			ST_ANG2: state_d = ST_DONE;
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Checks.
	// ------------------------------------------------------------------
	ap_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		LIM_W'(cnt_q) <= LIM_W'(STACK_DEPTH)) else $error("stack count beyond depth");
	ap_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !s_tready) else $error("second command taken while busy");
	ap_cordic_wait: assert property (@(posedge clk) disable iff (!arst_n)
		trig.done |-> state_q == ST_CORDIC) else $error("cordic finished out of turn");
	ap_ovf_keeps_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && nsts == STS_OVF |=> $stable(cnt_q)) else $error("refused push moved stack");

endmodule

>>> verif/turtle_pose_engine_with_stack_checker.sv
// ----------------------------------------------------------------------------
// turtle_pose_engine_with_stack_checker
// Watches the command, result and register channels of the turtle pose
// engine, predicts every result and compares it with what the block gives.
// ----------------------------------------------------------------------------
module turtle_pose_engine_with_stack_checker
	import tpe_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [39:0]  s_tdata,
	input  logic [2:0]   s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [135:0] m_tdata,
	input  logic         m_tuser,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	input  logic         pready,
	output int           fail_count,
	output int           pending,
	output int           lines_seen
);

	typedef struct packed {
		logic        line;
		logic [31:0] fx;
		logic [31:0] fy;
		logic [31:0] tx;
		logic [31:0] ty;
		logic [1:0]  sts;
	} segment_t;

	segment_t    segment_queue[$];
	logic [24:0] sc_x, sc_y;
	logic [31:0] st_x, st_y;
	logic [15:0] st_h;
	logic [5:0]  lim;
	longint      px, py;
	logic [31:0] ph;
	longint      sx[STACK_DEPTH], sy[STACK_DEPTH];
	logic [31:0] sh[STACK_DEPTH];
	int          depth;

	function automatic longint floor_shift(longint v, int n);
		return v >>> n;
	endfunction

	function automatic logic [31:0] units_to_angle(longint u);
		longint mag;
		logic [63:0] q;
		mag = (u < 0) ? -u : u;
		q = ((mag << 32) + UNITS_PER_TURN / 2) / UNITS_PER_TURN;
		return (u < 0) ? 32'(-q[31:0]) : q[31:0];
	endfunction

	function automatic logic [31:0] atan_tab(int i);
		logic [31:0] t[32] = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
			32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53,
			32'h00145F2F, 32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3,
			32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30,
			32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
			32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003,
			32'h00000001, 32'h00000001, 32'h00000000};
		return t[i];
	endfunction

	task automatic sine_cosine(input logic [31:0] h, output longint c, output longint s);
		logic        flip;
		longint      x, y, z, xs, ys;
		logic [31:0] hh;
		flip = (h[31:30] == 2'd1) || (h[31:30] == 2'd2);
		hh = flip ? h + 32'h80000000 : h;
		x = 652032874;
		y = 0;
		z = longint'($signed(hh));
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys; y += xs; z -= longint'(atan_tab(i));
			end else begin
				x += ys; y -= xs; z += longint'(atan_tab(i));
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	function automatic longint offset(longint d, longint trig, logic [24:0] scale);
		longint p;
		p = floor_shift(d * trig + (64'sd1 <<< 9), 10);
		return floor_shift(p * longint'({39'd0, scale}) + (64'sd1 <<< 23), 24);
	endfunction

	function automatic longint clamp(longint v, inout logic sat);
		if (v > 64'sd2147483647) begin
			sat = 1'b1; return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			sat = 1'b1; return -64'sd2147483648;
		end
		return v;
	endfunction

	// Advance the predicted pose by one command and queue the segment it gives.
	task automatic step_pose(input tpe_cmd_t cmd, input logic [15:0] step_len,
			input logic [16:0] ang);
		segment_t e;
		longint   c, s;
		logic     sat;
		int       cap;
		e = '0;
		e.fx = px[31:0];
		e.fy = py[31:0];
		cap = (lim < STACK_DEPTH) ? lim : STACK_DEPTH;
		sat = 1'b0;
		case (cmd)
			CMD_DRAW, CMD_MOVE: begin
				sine_cosine(ph, c, s);
				px = clamp(px + offset(longint'($signed(step_len)), c, sc_x), sat);
				py = clamp(py + offset(longint'($signed(step_len)), s, sc_y), sat);
				if (sat) e.sts = STS_SAT;
				e.line = (cmd == CMD_DRAW);
			end
			CMD_LEFT:  ph = ph + units_to_angle(longint'($signed(ang)));
			CMD_RIGHT: ph = ph - units_to_angle(longint'($signed(ang)));
			CMD_PUSH: begin
				if (depth >= cap) e.sts = STS_OVF;
				else begin
					sx[depth] = px; sy[depth] = py; sh[depth] = ph;
					depth++;
				end
			end
			CMD_POP: begin
				if (depth == 0) e.sts = STS_UNF;
				else begin
					depth--;
					px = sx[depth]; py = sy[depth]; ph = sh[depth];
				end
			end
			CMD_RESTART: begin
				px = longint'($signed(st_x));
				py = longint'($signed(st_y));
				ph = units_to_angle(longint'(st_h));
				depth = 0;
			end
			default: ;
		endcase
		e.tx = px[31:0];
		e.ty = py[31:0];
		segment_queue.push_back(e);
	endtask

	assign pending = segment_queue.size();

	always @(posedge clk or negedge arst_n) begin
		segment_t e, got;
		if (!arst_n) begin
			segment_queue.delete();
			sc_x <= 25'd16384; sc_y <= 25'd16384;
			st_x <= '0; st_y <= '0; st_h <= '0; lim <= 6'd32;
			px = 0; py = 0; ph = '0; depth = 0;
			fail_count <= 0;
			lines_seen <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (tpe_reg_t'(paddr[4:2]))
					REG_X_SCALE: sc_x <= pwdata[24:0];
					REG_Y_SCALE: sc_y <= pwdata[24:0];
					REG_START_X: st_x <= pwdata;
					REG_START_Y: st_y <= pwdata;
					REG_START_H: st_h <= pwdata[15:0];
					REG_STK_LIM: lim  <= pwdata[5:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				step_pose(tpe_cmd_t'(s_tuser), s_tdata[15:0], s_tdata[32:16]);
			if (m_tvalid && m_tready) begin
				got.line = m_tuser;
				got.fx = m_tdata[31:0];
				got.fy = m_tdata[63:32];
				got.tx = m_tdata[95:64];
				got.ty = m_tdata[127:96];
				got.sts = m_tdata[129:128];
				if (m_tuser) lines_seen <= lines_seen + 1;
				if (segment_queue.size() == 0) begin
					$display("%0t: result with none expected, actual %h", $time, got);
					fail_count <= fail_count + 1;
				end else begin
					e = segment_queue.pop_front();
					if (got !== e) begin
						$display("%0t: mismatch expected line %0b from %h,%h to %h,%h sts %0d",
							$time, e.line, e.fx, e.fy, e.tx, e.ty, e.sts);
						$display("%0t:          actual   line %0b from %h,%h to %h,%h sts %0d",
							$time, got.line, got.fx, got.fy, got.tx, got.ty, got.sts);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

>>> verif/turtle_pose_engine_with_stack_test.sv
// ----------------------------------------------------------------------------
// turtle_pose_engine_with_stack_test
// Drives commands and register settings into the turtle pose engine with
// random gaps and stalls; the checker beside it predicts and compares.
// ----------------------------------------------------------------------------
module turtle_pose_engine_with_stack_test;
	import tpe_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [39:0]  s_tdata = '0;
	logic [2:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [135:0] m_tdata;
	logic         m_tuser;
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [4:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;
	int           fail_count, pending, lines_seen;
	int           cycles = 0;
	int           sent = 0;
	// While set, the receiver stops accepting results so the engine backs up.
	logic         hold_off = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	turtle_pose_engine_with_stack u_dut (.*);

	turtle_pose_engine_with_stack_checker u_chk (.*);

	// Receiver: before each result it draws a random wait, and it
	// stops altogether during the hold-off stretch.
	initial begin
		int w;
		@(posedge arst_n);
		forever begin
			w = $urandom_range(0, 4);
			if (w != 0 || hold_off) begin
				m_tready <= 1'b0;
				repeat (w) @(negedge clk);
				while (hold_off) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			@(negedge clk);
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Register write: setup cycle then access cycle, both on falling edges.
	task automatic reg_write(input tpe_reg_t idx, input logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	// Offer one command after a random gap and hold it until transferred.
	// Valid drops during a gap; with no gap the next command follows at once.
	task automatic send_cmd(input tpe_cmd_t cmd, input logic [15:0] step_len,
			input logic [16:0] ang);
		int w;
		w = $urandom_range(0, 4);
		if (w != 0) begin
			s_tvalid <= 1'b0;
			repeat (w) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {7'd0, ang, step_len};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	// Every command produces one result, so an empty queue means nothing is expected;
	// a wait then lets the engine settle back to idle before a register write.
	task automatic drain;
		s_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic logic [16:0] rand_angle();
		case ($urandom_range(0, 3))
			0: return 17'($signed($urandom_range(0, 92160)) - 46080);
			1: return 17'(11520 * $urandom_range(0, 4));
			2: return 17'($urandom);
			default: return 17'($urandom_range(0, 2000));
		endcase
	endfunction

	function automatic logic [15:0] rand_dist();
		case ($urandom_range(0, 3))
			0: return 16'($urandom);
			1: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
			default: return 16'($signed($urandom_range(0, 1600)) - 800);
		endcase
	endfunction

	// A well-formed branch: a push and one to four draws or turns per level, then pop back.
	task automatic branch_burst(input int levels);
		int n;
		for (int l = 0; l < levels; l++) begin
			send_cmd(CMD_PUSH, 16'($urandom), 17'($urandom));
			n = $urandom_range(1, 4);
			for (int k = 0; k < n; k++) begin
				if ($urandom_range(0, 1)) send_cmd(CMD_DRAW, rand_dist(), 17'($urandom));
				else send_cmd($urandom_range(0, 1) ? CMD_LEFT : CMD_RIGHT,
					16'($urandom), rand_angle());
			end
		end
		for (int l = 0; l < levels; l++)
			send_cmd(CMD_POP, 16'($urandom), 17'($urandom));
	endtask

	task automatic random_phase(input int count);
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 45) branch_burst($urandom_range(1, 4));
			else if (r < 60) send_cmd(CMD_DRAW, rand_dist(), 17'($urandom));
			else if (r < 70) send_cmd(CMD_MOVE, rand_dist(), 17'($urandom));
			else if (r < 80) send_cmd(CMD_LEFT, 16'($urandom), rand_angle());
			else if (r < 85) send_cmd(CMD_RIGHT, 16'($urandom), rand_angle());
			else if (r < 90) send_cmd(CMD_PUSH, 16'($urandom), 17'($urandom));
			else if (r < 95) send_cmd(CMD_POP, 16'($urandom), 17'($urandom));
			else if (r < 98) send_cmd(CMD_RESTART, 16'($urandom), 17'($urandom));
			else send_cmd(CMD_NONE, 16'($urandom), 17'($urandom));
		end
	endtask

	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Directed part with reset settings: every command, field extremes,
		// underflow on an empty stack and the unused command code.
		send_cmd(CMD_POP, 16'h0000, 17'h00000);
		send_cmd(CMD_DRAW, 16'h7FFF, 17'h00000);
		send_cmd(CMD_MOVE, 16'h8000, 17'h1FFFF);
		send_cmd(CMD_LEFT, 16'hFFFF, 17'sd46080);
		send_cmd(CMD_LEFT, 16'h0000, -17'sd46080);
		send_cmd(CMD_RIGHT, 16'h0000, 17'sd11520);
		send_cmd(CMD_DRAW, 16'h0010, 17'h0FFFF);
		send_cmd(CMD_PUSH, 16'h0000, 17'h00000);
		send_cmd(CMD_RIGHT, 16'h0000, 17'h10000);
		send_cmd(CMD_DRAW, 16'h8000, 17'h00000);
		send_cmd(CMD_POP, 16'h0000, 17'h00000);
		send_cmd(CMD_NONE, 16'hFFFF, 17'h1FFFF);
		send_cmd(CMD_RESTART, 16'h0000, 17'h00000);
		drain();

		// Large scales and an edge start pose drive the position into
		// saturation; a stack limit of one makes the second push overflow.
		reg_write(REG_X_SCALE, 32'd16777216);
		reg_write(REG_Y_SCALE, 32'h01FFFFFF);
		reg_write(REG_START_X, 32'h7FFF0000);
		reg_write(REG_START_Y, 32'h80000000);
		reg_write(REG_START_H, 32'd46079);
		reg_write(REG_STK_LIM, 32'd1);
		send_cmd(CMD_RESTART, 16'h0000, 17'h00000);
		send_cmd(CMD_DRAW, 16'h7FFF, 17'h00000);
		send_cmd(CMD_PUSH, 16'h0000, 17'h00000);
		send_cmd(CMD_PUSH, 16'h0000, 17'h00000);
		send_cmd(CMD_LEFT, 16'h0000, 17'sd23040);
		send_cmd(CMD_MOVE, 16'h8000, 17'h00000);
		send_cmd(CMD_POP, 16'h0000, 17'h00000);
		drain();

		// Two pushes under the full limit, then the limit lowered below the count: a push refused, a pop still works.
		reg_write(REG_STK_LIM, 32'd32);
		send_cmd(CMD_PUSH, 16'h0000, 17'h00000);
		send_cmd(CMD_PUSH, 16'h0000, 17'h00000);
		drain();
		reg_write(REG_STK_LIM, 32'd0);
		send_cmd(CMD_PUSH, 16'h0000, 17'h00000);
		send_cmd(CMD_POP, 16'h0000, 17'h00000);
		drain();

		// Random phases under several settings.
		for (int ph_i = 0; ph_i < 4; ph_i++) begin
			case (ph_i)
				0: begin
					reg_write(REG_X_SCALE, 32'd16384); reg_write(REG_Y_SCALE, 32'd16384);
					reg_write(REG_STK_LIM, 32'd32);
				end
				1: begin
					reg_write(REG_X_SCALE, 32'd1); reg_write(REG_Y_SCALE, 32'd1);
					reg_write(REG_STK_LIM, 32'd3);
				end
				2: begin
					reg_write(REG_X_SCALE, $urandom_range(1, 16777216));
					reg_write(REG_Y_SCALE, 32'($urandom));
					reg_write(REG_STK_LIM, 32'd63);
				end
				default: begin
					reg_write(REG_X_SCALE, 32'd16777216);
					reg_write(REG_Y_SCALE, 32'd16777216);
					reg_write(REG_STK_LIM, $urandom_range(0, 32));
				end
			endcase
			reg_write(REG_START_X, $urandom);
			reg_write(REG_START_Y, $urandom);
			reg_write(REG_START_H, $urandom_range(0, 65535));
			send_cmd(CMD_RESTART, 16'h0000, 17'h00000);
			if (ph_i == 1) begin
				// Long receiver hold-off while the sender keeps offering.
				hold_off <= 1'b1;
				fork
					begin
						repeat (300) @(posedge clk);
						hold_off <= 1'b0;
					end
					random_phase(10);
				join
			end else
				random_phase(35);
			drain();
		end

		repeat (40) @(posedge clk);
		$display("Run sent %0d commands under several scale, start and limit settings,", sent);
		$display("with %0d drawn segments checked, including saturation and stack limits.",
			lines_seen);
		if (fail_count == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
